### design/weh_pkg.sv
// ----------------------------------------------------------------------------
// weh_pkg: shared types and constants of the weighted energy histogram.
// Store geometry, field widths, register indexes and the front-to-back job.
// ----------------------------------------------------------------------------
package weh_pkg;

  localparam int MAX_BINS       = 4096;
  localparam int PARTICLE_TYPES = 3;
  localparam int COLUMNS        = PARTICLE_TYPES + 1;

  localparam int BIN_W  = $clog2(MAX_BINS);
  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CELL_W = 64;
  localparam int ROW_W  = CELL_W * COLUMNS;

  // Field widths.
  localparam int ENERGY_W = 32;
  localparam int WEIGHT_W = 32;
  localparam int PTYPE_W  = 2;
  localparam int HINC_W   = 32;
  localparam int RBIN_W   = 12;
  localparam int RCOL_W   = 2;
  localparam int HIST_W   = 64;

  // Configuration registers.
  localparam int EMIN_W   = 32;
  localparam int KQ_W     = 48;
  localparam int KQ_HALF  = 24;
  localparam int KQ_FRAC  = 40;
  localparam int BUSED_W  = 13;
  localparam int CFG_W    = 48;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_PER_EV = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_USED  = 2'd2;

  localparam logic [KQ_W-1:0]    KQ_RESET    = 48'h010000000000;
  localparam logic [BUSED_W-1:0] BUSED_RESET = 13'd4096;

  // Bin arithmetic widths.
  localparam int PROD_W = ENERGY_W + KQ_HALF;           // 56
  localparam int SUM_W  = PROD_W + 1;                   // 57
  localparam int BFULL_W = SUM_W - (KQ_FRAC - KQ_HALF); // 41

  // Queue between front and back.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Stream packing.
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 144;

  typedef struct packed {
    logic                is_read;
    logic [BIN_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic                in_range;
    logic                add_en;
    logic                cell_ok;
    logic [WEIGHT_W-1:0] weight;
    logic [HINC_W-1:0]   hinc;
  } job_t;

endpackage

### design/weh_front.sv
// ----------------------------------------------------------------------------
// weh_front: request intake and bin classification.
// Holds the configuration registers and computes the bin of each record.
// ----------------------------------------------------------------------------
module weh_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [weh_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [weh_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              clearing_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic [weh_pkg::ENERGY_W-1:0]      energy_i,
  input  logic [weh_pkg::WEIGHT_W-1:0]      weight_i,
  input  logic [weh_pkg::PTYPE_W-1:0]       ptype_i,
  input  logic [weh_pkg::HINC_W-1:0]        hinc_i,
  input  logic [weh_pkg::RBIN_W-1:0]        rbin_i,
  input  logic [weh_pkg::RCOL_W-1:0]        rcol_i,
  output logic                              push_valid_o,
  input  logic                              push_ready_i,
  output weh_pkg::job_t                     push_job_o
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_BIN} fstate_e;

  fstate_e state_q, state_d;

  logic [weh_pkg::EMIN_W-1:0]  emin_q;
  logic [weh_pkg::KQ_W-1:0]    kq_q;
  logic [weh_pkg::BUSED_W-1:0] bused_q;

  logic [weh_pkg::ENERGY_W:0]   diff_q;
  logic                         func_q;
  logic [weh_pkg::WEIGHT_W-1:0] weight_q;
  logic [weh_pkg::PTYPE_W-1:0]  ptype_q;
  logic [weh_pkg::HINC_W-1:0]   hinc_q;
  logic [weh_pkg::RBIN_W-1:0]   rbin_q;
  logic [weh_pkg::RCOL_W-1:0]   rcol_q;
  logic [weh_pkg::PROD_W-1:0]   plo_q, phi_q;

  logic                          accept;
  logic [weh_pkg::SUM_W-1:0]     hi_sum;
  logic [weh_pkg::BFULL_W-1:0]   bin_full;
  logic [weh_pkg::BUSED_W-1:0]   limit;
  logic                          in_r;

  assign in_ready_o = (state_q == F_IDLE) && !clearing_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    limit = (bused_q > weh_pkg::BUSED_W'(weh_pkg::MAX_BINS)) ?
            weh_pkg::BUSED_W'(weh_pkg::MAX_BINS) : bused_q;
    hi_sum = weh_pkg::SUM_W'(phi_q) +
             weh_pkg::SUM_W'(plo_q[weh_pkg::PROD_W-1:weh_pkg::KQ_HALF]);
    bin_full = hi_sum[weh_pkg::SUM_W-1:weh_pkg::KQ_FRAC-weh_pkg::KQ_HALF];
    // The borrow bit of the difference marks an energy below the minimum.
    in_r = !func_q && !diff_q[weh_pkg::ENERGY_W] &&
           (bin_full < weh_pkg::BFULL_W'(limit));

    push_job_o.is_read  = func_q;
    push_job_o.row      = func_q ? weh_pkg::BIN_W'(rbin_q) :
                          (in_r ? bin_full[weh_pkg::BIN_W-1:0] : '0);
    push_job_o.col      = func_q ? weh_pkg::COL_W'(rcol_q) :
                          weh_pkg::COL_W'(ptype_q) + weh_pkg::COL_W'(1);
    push_job_o.in_range = in_r;
    push_job_o.add_en   = in_r && (int'(ptype_q) < weh_pkg::PARTICLE_TYPES);
    push_job_o.cell_ok  = func_q && (int'(rbin_q) < weh_pkg::MAX_BINS) &&
                          (int'(rcol_q) <= weh_pkg::PARTICLE_TYPES);
    push_job_o.weight   = weight_q;
    push_job_o.hinc     = hinc_q;
  end

  assign push_valid_o = (state_q == F_BIN);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (accept) state_d = F_MUL;
      F_MUL:  state_d = F_BIN;
      F_BIN:  if (push_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      emin_q  <= '0;
      kq_q    <= weh_pkg::KQ_RESET;
      bused_q <= weh_pkg::BUSED_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          weh_pkg::REG_ENERGY_MIN:  emin_q  <= cfg_data_i[weh_pkg::EMIN_W-1:0];
          weh_pkg::REG_BINS_PER_EV: kq_q    <= cfg_data_i[weh_pkg::KQ_W-1:0];
          weh_pkg::REG_BINS_USED:   bused_q <= cfg_data_i[weh_pkg::BUSED_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      diff_q   <= {1'b0, energy_i} - {1'b0, emin_q};
      func_q   <= func_i;
      weight_q <= weight_i;
      ptype_q  <= ptype_i;
      hinc_q   <= hinc_i;
      rbin_q   <= rbin_i;
      rcol_q   <= rcol_i;
    end
    if (state_q == F_MUL) begin
      plo_q <= weh_pkg::PROD_W'(diff_q[weh_pkg::ENERGY_W-1:0] *
                                kq_q[weh_pkg::KQ_HALF-1:0]);
      phi_q <= weh_pkg::PROD_W'(diff_q[weh_pkg::ENERGY_W-1:0] *
                                kq_q[weh_pkg::KQ_W-1:weh_pkg::KQ_HALF]);
    end
  end

endmodule

### design/weh_fifo.sv
// ----------------------------------------------------------------------------
// weh_fifo: short job queue between the front and the back.
// Lets the front take new requests while the back is still busy.
// ----------------------------------------------------------------------------
module weh_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  weh_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output weh_pkg::job_t pop_job_o
);

  weh_pkg::job_t entry_q [weh_pkg::FIFO_DEPTH];

  logic [weh_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [weh_pkg::FIFO_CNT_W-1:0] count_q;
  logic                           push, pop;

  assign push_ready_o = (count_q != weh_pkg::FIFO_CNT_W'(weh_pkg::FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = entry_q[rd_ptr_q];

  function automatic logic [weh_pkg::FIFO_PTR_W-1:0] next_ptr(
    input logic [weh_pkg::FIFO_PTR_W-1:0] p
  );
    next_ptr = (p == weh_pkg::FIFO_PTR_W'(weh_pkg::FIFO_DEPTH - 1)) ?
               '0 : p + weh_pkg::FIFO_PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push && !pop)      count_q <= count_q + weh_pkg::FIFO_CNT_W'(1);
      else if (pop && !push) count_q <= count_q - weh_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_job_i;
  end

endmodule

### design/weh_back.sv
// ----------------------------------------------------------------------------
// weh_back: spectrum store, read-modify-write and result register.
// Clears the store after reset, then updates at most one row per record.
// ----------------------------------------------------------------------------
module weh_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  output logic                            clearing_o,
  input  logic                            pop_valid_i,
  output logic                            pop_ready_o,
  input  weh_pkg::job_t                   pop_job_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [weh_pkg::BIN_W-1:0]       out_bin_o,
  output logic                            out_in_range_o,
  output logic [weh_pkg::CELL_W-1:0]      out_cell_o,
  output logic [weh_pkg::HIST_W-1:0]      out_hist_o
);

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_UPD} bstate_e;

  bstate_e state_q;

  logic [weh_pkg::ROW_W-1:0] mem [weh_pkg::MAX_BINS];
  logic [weh_pkg::ROW_W-1:0] rd_q;

  logic [weh_pkg::BIN_W-1:0]  clr_q;
  weh_pkg::job_t              job_q;
  logic [weh_pkg::HIST_W-1:0] hist_q;

  logic                       out_valid_q;
  logic [weh_pkg::BIN_W-1:0]  out_bin_q;
  logic                       out_inr_q;
  logic [weh_pkg::CELL_W-1:0] out_cell_q;
  logic [weh_pkg::HIST_W-1:0] out_hist_q;

  logic                       out_free, pop;
  logic                       mem_we;
  logic [weh_pkg::BIN_W-1:0]  mem_waddr;
  logic [weh_pkg::ROW_W-1:0]  mem_wdata, row_upd;
  logic [weh_pkg::CELL_W-1:0] cell_rd;
  logic [weh_pkg::HIST_W-1:0] hist_d;

  function automatic logic [weh_pkg::CELL_W-1:0] add_sat(
    input logic [weh_pkg::CELL_W-1:0]   a,
    input logic [weh_pkg::WEIGHT_W-1:0] w
  );
    logic [weh_pkg::CELL_W:0] s;
    s = {1'b0, a} + (weh_pkg::CELL_W + 1)'(w);
    add_sat = s[weh_pkg::CELL_W] ? '1 : s[weh_pkg::CELL_W-1:0];
  endfunction

  assign clearing_o  = (state_q == B_CLEAR);
  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_ready_o = (state_q == B_IDLE) && out_free;
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    row_upd = rd_q;
    row_upd[0 +: weh_pkg::CELL_W] =
      add_sat(rd_q[0 +: weh_pkg::CELL_W], job_q.weight);
    row_upd[job_q.col * weh_pkg::CELL_W +: weh_pkg::CELL_W] =
      add_sat(rd_q[job_q.col * weh_pkg::CELL_W +: weh_pkg::CELL_W], job_q.weight);
    cell_rd = (job_q.is_read && job_q.cell_ok) ?
              rd_q[job_q.col * weh_pkg::CELL_W +: weh_pkg::CELL_W] : '0;
    hist_d  = job_q.is_read ? hist_q :
              hist_q + weh_pkg::HIST_W'(job_q.hinc);
    mem_we    = 1'b0;
    mem_waddr = job_q.row;
    mem_wdata = row_upd;
    if (state_q == B_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == B_UPD && job_q.add_en) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      hist_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        B_CLEAR: begin
          clr_q <= clr_q + weh_pkg::BIN_W'(1);
          if (clr_q == weh_pkg::BIN_W'(weh_pkg::MAX_BINS - 1)) state_q <= B_IDLE;
        end
        B_IDLE: if (pop) state_q <= B_UPD;
        B_UPD: begin
          hist_q      <= hist_d;
          out_valid_q <= 1'b1;
          state_q     <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      job_q <= pop_job_i;
      rd_q  <= mem[pop_job_i.row];
    end
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (state_q == B_UPD) begin
      out_bin_q  <= job_q.is_read ? '0 : job_q.row;
      out_inr_q  <= job_q.in_range;
      out_cell_q <= cell_rd;
      out_hist_q <= hist_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_bin_o      = out_bin_q;
  assign out_in_range_o = out_inr_q;
  assign out_cell_o     = out_cell_q;
  assign out_hist_o     = out_hist_q;

endmodule

### design/weighted_energy_histogram.sv
// ----------------------------------------------------------------------------
// weighted_energy_histogram: weighted energy spectrum accumulator.
// Flow: front difference, multiply and bin steps, job queue, back update, result.
// The front takes a new request only once its last job is pushed into the queue.
// Reset: a store clearing pass over every row runs; no request is taken meanwhile.
// ----------------------------------------------------------------------------
module weighted_energy_histogram (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [weh_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [weh_pkg::CFG_W-1:0]         cfg_data_i,
  // Request stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // energy[31:0], weight[63:32], particle_type[65:64],
  // history_increment[97:66], read_bin[109:98], read_column[111:110]
  input  logic [weh_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // func[0]: 0 record a particle, 1 read one cell
  input  logic                              s_axis_tuser,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // bin_index[11:0], in_range[12], cell_value[76:13],
  // history_total[140:77], zero fill [143:141]
  output logic [weh_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  // The front takes a request, forms energy minus minimum, multiplies the
  // difference by both halves of the inverse bin width, then adds the partial
  // products and compares the bin with the bins in use. The finished job goes
  // into a two-entry queue.
  //
  // The back pops a job, reads the whole bin row (all columns) from the store,
  // adds the weight with saturation to the total and particle columns, writes
  // the row back for an in-range record of a valid type, loads the result
  // register. Read and write back are on separate cycles: no forwarding needed.

  logic          clearing;
  logic          push_valid, push_ready, pop_valid, pop_ready;
  weh_pkg::job_t push_job, pop_job;

  logic [weh_pkg::BIN_W-1:0]  out_bin;
  logic                       out_inr;
  logic [weh_pkg::CELL_W-1:0] out_cell;
  logic [weh_pkg::HIST_W-1:0] out_hist;

  weh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .clearing_i   (clearing),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .func_i       (s_axis_tuser),
    .energy_i     (s_axis_tdata[31:0]),
    .weight_i     (s_axis_tdata[63:32]),
    .ptype_i      (s_axis_tdata[65:64]),
    .hinc_i       (s_axis_tdata[97:66]),
    .rbin_i       (s_axis_tdata[109:98]),
    .rcol_i       (s_axis_tdata[111:110]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  weh_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  weh_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .clearing_o     (clearing),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_job_i      (pop_job),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_bin_o      (out_bin),
    .out_in_range_o (out_inr),
    .out_cell_o     (out_cell),
    .out_hist_o     (out_hist)
  );

  // Pack the result fields from the lowest bit up and fill to whole bytes.
  assign m_axis_tdata = {3'b000, out_hist, out_cell, out_inr, out_bin};

endmodule
